### hw/rtl/pcls_pkg.sv
// Shared types for the per-channel latency statistics block.
// Transaction payload structs, request codes and controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcls_pkg;

  localparam int unsigned CntW = 32;
  localparam int unsigned DelayW = 32;
  localparam int unsigned ChanW = 4;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [1:0] {
    REQ_PRODUCED = 2'd0,
    REQ_CONSUMED = 2'd1,
    REQ_READ     = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    req_e               req_type;
    logic [ChanW-1:0]   channel;
    logic [DelayW-1:0]  delay;
  } pcls_in_t;

  typedef struct packed {
    logic [ChanW-1:0]   out_channel;
    logic [CntW-1:0]    made_count;
    logic [CntW-1:0]    eaten_count;
    logic               has_delay;
    logic [DelayW-1:0]  shortest_delay;
    logic [DelayW-1:0]  mean_delay;
    logic [DelayW-1:0]  longest_delay;
    logic               mismatch;
  } pcls_out_t;

endpackage

`default_nettype wire

### hw/rtl/pcls_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data registered; it appears in the cycle after the read enable. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/pcls_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Dividend DW bits, divisor VW bits (nonzero). No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcls_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic      [DW-1:0] quotient_o
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] den_q, den_d;
  logic [VW:0]   rem_sh;
  logic          fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? VW'(rem_sh - {1'b0, den_q}) : rem_sh[VW-1:0];
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### hw/rtl/per_channel_latency_stats.sv
// Per-channel latency statistics: top level, controller and update datapath.
// Depends on pcls_pkg, pcls_ram, pcls_div.
//
//  channel | signals                          | carries
//  --------+----------------------------------+---------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i  | request: type, channel, delay
//  out     | out_valid_o, out_ready_i, out_data_o | updated entry, mismatch flag
//
// One transaction at a time. Produced, read and first-sample consumed requests
// pass through accept, RAM read and write back. A later consumed request adds
// the mean divider between RAM read and write back. Reset clears per-entry
// valid bits at once; an invalid entry reads as zero, so no clearing pass is
// needed. A new request is taken while a result waits in the output register;
// write back stalls only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module per_channel_latency_stats
  import pcls_pkg::*;
#(
  parameter int unsigned CHANNELS           = 16,
  parameter int unsigned MEAN_FRACTION_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pcls_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output pcls_out_t      out_data_o
);

  localparam int unsigned MeanW  = DelayW + MEAN_FRACTION_BITS;
  localparam int unsigned EntryW = 2 * CntW + 2 * DelayW + MeanW;
  localparam int unsigned AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // FSM
  state_e state_q, state_d;
  logic   in_fire, div_start, div_done, ram_we, out_load, out_free;

  // working copy of the addressed entry
  pcls_in_t          req_q;
  logic [AW-1:0]     idx_q;
  logic              oor_q;
  logic              neg_q;
  logic [CntW-1:0]   made_q, made_d;
  logic [CntW-1:0]   eaten_q, eaten_d;
  logic [DelayW-1:0] min_q, min_d;
  logic [DelayW-1:0] max_q, max_d;
  logic [MeanW-1:0]  mean_q, mean_d;
  logic              neg_d;
  logic [MeanW-1:0]  diff;
  logic [MeanW-1:0]  quot;
  logic              need_div;

  // storage
  logic [CHANNELS-1:0] valid_q;
  logic [EntryW-1:0]   ram_rdata, rd_entry, ram_wdata;
  logic [AW-1:0]       in_idx;
  logic                in_range;

  // entry fields as read
  logic [CntW-1:0]   rd_made, rd_eaten;
  logic [DelayW-1:0] rd_min, rd_max;
  logic [MeanW-1:0]  rd_mean, sample;

  // output register
  logic      out_valid_q;
  pcls_out_t out_q, out_d;

  assign in_fire  = in_valid_i && in_ready_o;
  assign in_idx   = AW'(in_data_i.channel);
  assign in_range = 32'(in_data_i.channel) < 32'(CHANNELS);
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------- controller ----------------
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (oor_q) begin
          state_d = ST_DONE;
        end else if (need_div) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = !oor_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- entry store ----------------
  pcls_ram #(
    .WIDTH (EntryW),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  assign rd_entry  = valid_q[idx_q] ? ram_rdata : '0;
  assign rd_made   = rd_entry[EntryW-1 -: CntW];
  assign rd_eaten  = rd_entry[EntryW-CntW-1 -: CntW];
  assign rd_min    = rd_entry[MeanW+2*DelayW-1 -: DelayW];
  assign rd_max    = rd_entry[MeanW+DelayW-1 -: DelayW];
  assign rd_mean   = rd_entry[MeanW-1:0];
  assign ram_wdata = {made_q, eaten_q, min_q, max_q, mean_q};
  assign sample    = MeanW'(req_q.delay) << MEAN_FRACTION_BITS;

  // ---------------- update datapath ----------------
  pcls_div #(
    .DW (MeanW),
    .VW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (eaten_d),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    made_d   = made_q;
    eaten_d  = eaten_q;
    min_d    = min_q;
    max_d    = max_q;
    mean_d   = mean_q;
    neg_d    = neg_q;
    diff     = '0;
    need_div = 1'b0;
    if (state_q == ST_READ) begin
      made_d  = rd_made;
      eaten_d = rd_eaten;
      min_d   = rd_min;
      max_d   = rd_max;
      mean_d  = rd_mean;
      unique case (req_q.req_type)
        REQ_PRODUCED: begin
          if (rd_made != CntMax) begin
            made_d = rd_made + 1'b1;
          end
        end
        REQ_CONSUMED: begin
          if (rd_eaten != CntMax) begin
            eaten_d = rd_eaten + 1'b1;
          end
          if (eaten_d == CntW'(1)) begin
            // first sample seeds all three statistics
            min_d  = req_q.delay;
            max_d  = req_q.delay;
            mean_d = sample;
          end else begin
            if (req_q.delay < rd_min) begin
              min_d = req_q.delay;
            end
            if (req_q.delay > rd_max) begin
              max_d = req_q.delay;
            end
            neg_d    = sample < rd_mean;
            diff     = neg_d ? rd_mean - sample : sample - rd_mean;
            need_div = 1'b1;
          end
        end
        default: ;  // read, or unused code treated as read
      endcase
    end else if (state_q == ST_DIV && div_done) begin
      // truncation toward zero on the magnitude
      mean_d = neg_q ? mean_q - quot : mean_q + quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
      idx_q <= in_idx;
      oor_q <= !in_range;
    end
    made_q  <= made_d;
    eaten_q <= eaten_d;
    min_q   <= min_d;
    max_q   <= max_d;
    mean_q  <= mean_d;
    neg_q   <= neg_d;
  end

  // ---------------- result register ----------------
  always_comb begin
    out_d             = '0;
    out_d.out_channel = req_q.channel;
    if (!oor_q) begin
      out_d.made_count  = made_q;
      out_d.eaten_count = eaten_q;
      out_d.mismatch    = made_q != eaten_q;
      if (eaten_q != '0) begin
        out_d.has_delay      = 1'b1;
        out_d.shortest_delay = min_q;
        out_d.mean_delay     = mean_q[MeanW-1:MEAN_FRACTION_BITS];
        out_d.longest_delay  = max_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/pcls_checker.sv
// Port-level checks for per_channel_latency_stats, attached by bind.
// Depends on pcls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcls_checker
  import pcls_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire pcls_out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // has_delay tracks the consumed count; no delay means zero statistics
  a_no_delay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_delay |->
      out_data_o.eaten_count == '0 && out_data_o.shortest_delay == '0 &&
      out_data_o.mean_delay == '0 && out_data_o.longest_delay == '0)
    else $error("delay fields set without a recorded delay");

  // running mean stays between min and max
  a_mean_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_delay |->
      out_data_o.shortest_delay <= out_data_o.mean_delay &&
      out_data_o.mean_delay <= out_data_o.longest_delay &&
      out_data_o.eaten_count != '0)
    else $error("mean outside min/max");

endmodule

bind per_channel_latency_stats pcls_checker u_pcls_checker (.*);

`default_nettype wire
